@@ sv/wpqe_pkg.sv @@
// ----------------------------------------------------------------------------
// wpqe_pkg: shared definitions of the wide polyline quad expander
// widths, reset values, register indexes and fixed-point constants
// ----------------------------------------------------------------------------
package wpqe_pkg;

   localparam int COORD_BITS = 16;
   localparam int HW_W       = 16;
   localparam int ZOOM_W     = 16;
   localparam int RGBA_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CORNER_W   = 2;

   localparam int T_W        = 10;
   localparam int NHALF_W    = T_W + 10;
   localparam int F_W        = 17;
   localparam int WE_W       = 17;
   localparam int NORM_W     = 30;
   localparam int MUL_W      = 2 * NORM_W;
   localparam int ACC_W      = 62;
   localparam int LEN_W      = 31;
   localparam int QUO_W      = 14;
   localparam int OFS_W      = 15;
   localparam int CNT_W      = 5;

   localparam int ROOT_STEPS = 31;
   localparam int QUO_STEPS  = QUO_W;
   localparam int DEN_SHIFT  = 4;

   localparam logic [HW_W-1:0]   HALF_WIDTH_RESET   = 16'd1024;
   localparam logic [ZOOM_W-1:0] MAP_ZOOM_RESET     = 16'd140;
   localparam logic [RGBA_W-1:0] VERTEX_COLOR_RESET = 32'hFF00_D4EB;

   localparam logic [ZOOM_W-1:0] ZOOM_BIAS  = 16'd140;
   localparam logic [ZOOM_W-1:0] ZOOM_LO    = 16'd280;
   localparam logic [ZOOM_W-1:0] ZOOM_HI    = 16'd1100;
   localparam logic [T_W-1:0]    ZOOM_T_MIN = 10'd140;
   localparam logic [T_W-1:0]    ZOOM_T_MAX = 10'd960;

   // floor(n/15) estimate: n*RECIP15 >> RECIP15_SHIFT, at most one too high
   localparam logic [15:0] RECIP15       = 16'd34953;
   localparam int          RECIP15_SHIFT = 19;
   localparam logic [F_W-1:0] F_OFFSET   = 17'd26214;
   localparam logic [MUL_W-1:0] WE_ROUND = 60'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WIDTH   = 2'd0,
      CSR_MAP_MODE     = 2'd1,
      CSR_MAP_ZOOM     = 2'd2,
      CSR_VERTEX_COLOR = 2'd3
   } csr_index_type;

   typedef enum logic [CORNER_W-1:0] {
      CORNER_PREV_MINUS = 2'd0,
      CORNER_CUR_MINUS  = 2'd1,
      CORNER_PREV_PLUS  = 2'd2,
      CORNER_CUR_PLUS   = 2'd3
   } corner_type;

endpackage

@@ sv/wide_polyline_quad_expander.sv @@
// ----------------------------------------------------------------------------
// wide_polyline_quad_expander: polyline to quad strip expansion
// Turns each polyline segment into four offset vertices of a wide line.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time and req_ready is low while it runs.
// A point with no stored predecessor emits nothing. For a segment, the
// length is found by a 31-step square root and each offset component by
// a 14-step restoring divide, all on one shared 62-bit subtractor, with one
// shared 30x30 multiplier for squares, width scaling and numerators. A
// zero-length segment skips the root and divides. The four vertices leave
// through an output register, so the last vertex may still wait on rsp_ready
// while the next point is taken.
// ----------------------------------------------------------------------------
module wide_polyline_quad_expander (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [wpqe_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [wpqe_pkg::COORD_BITS-1:0] req_point_y,
   input  logic                                   req_last_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [wpqe_pkg::COORD_BITS-1:0] rsp_vertex_x,
   output logic signed [wpqe_pkg::COORD_BITS-1:0] rsp_vertex_y,
   output logic [wpqe_pkg::RGBA_W-1:0]            rsp_vertex_rgba,
   output logic [wpqe_pkg::CORNER_W-1:0]          rsp_corner,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_write,
   input  logic [wpqe_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wpqe_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import wpqe_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE       = 15'b000_0000_0000_0001,
      ST_WID_MUL    = 15'b000_0000_0000_0010,
      ST_WID_FIX    = 15'b000_0000_0000_0100,
      ST_WE_MUL     = 15'b000_0000_0000_1000,
      ST_WE_RND     = 15'b000_0000_0001_0000,
      ST_NORM_ABS   = 15'b000_0000_0010_0000,
      ST_NORM_SHIFT = 15'b000_0000_0100_0000,
      ST_SQ_X       = 15'b000_0000_1000_0000,
      ST_SQ_Y       = 15'b000_0001_0000_0000,
      ST_SQ_SUM     = 15'b000_0010_0000_0000,
      ST_ROOT       = 15'b000_0100_0000_0000,
      ST_QUO_MUL    = 15'b000_1000_0000_0000,
      ST_QUO_LOAD   = 15'b001_0000_0000_0000,
      ST_QUO_DIV    = 15'b010_0000_0000_0000,
      ST_EMIT       = 15'b100_0000_0000_0000
   } state_type;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [ACC_W-2:0] ROOT_BIT_INIT = (ACC_W-1)'(1) << (2 * (ROOT_STEPS - 1));

   function automatic logic [CNT_W-1:0] msb_index(input logic [COORD_BITS-1:0] v);
      logic [CNT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < COORD_BITS; i++) begin
         if (v[i]) idx = CNT_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [COORD_BITS-1:0] sat_coord(input logic [COORD_BITS:0] v);
      logic [COORD_BITS-1:0] r;
      if (v[COORD_BITS] != v[COORD_BITS-1]) r = v[COORD_BITS] ? COORD_MIN : COORD_MAX;
      else r = v[COORD_BITS-1:0];
      return r;
   endfunction

   state_type                     state_ff, state_in;
   logic [HW_W-1:0]               half_width_ff, half_width_in;
   logic                          map_mode_ff, map_mode_in;
   logic [ZOOM_W-1:0]             map_zoom_ff, map_zoom_in;
   logic [RGBA_W-1:0]             vertex_color_ff, vertex_color_in;

   logic signed [COORD_BITS-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                          have_prev_ff, have_prev_in;
   logic signed [COORD_BITS-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                          last_ff, last_in;
   logic signed [COORD_BITS:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [NORM_W-1:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic [F_W-1:0]                f_ff, f_in;
   logic [WE_W-1:0]               we_ff, we_in;
   logic [MUL_W-1:0]              prod_ff, prod_in;
   logic [ACC_W-1:0]              rem_ff, rem_in, root_ff, root_in;
   logic [ACC_W-2:0]              bit_ff, bit_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [QUO_W-1:0]              quo_ff, quo_in;
   logic                          phase_ff, phase_in;
   logic signed [OFS_W-1:0]       ox_ff, ox_in, oy_ff, oy_in;
   logic [CORNER_W-1:0]           corner_ff, corner_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [RGBA_W-1:0]             out_rgba_ff, out_rgba_in;
   logic [CORNER_W-1:0]           out_corner_ff, out_corner_in;
   logic                          out_last_ff, out_last_in;

   // width scaling
   logic [T_W-1:0]                zoom_t;
   logic [NHALF_W-1:0]            n_half;
   logic [F_W-1:0]                q0;
   logic [F_W+3:0]                q0_x15;
   logic [F_W-1:0]                f_calc;
   logic [WE_W-1:0]               we_round;
   logic [MUL_W-1:0]              we_sum;

   // normalization
   logic [COORD_BITS:0]           dx_mag, dy_mag;
   logic [CNT_W-1:0]              norm_shift;
   logic [WE_W:0]                 zl_sum;
   logic signed [OFS_W-1:0]       zl_ofs;

   // shared units
   logic [NORM_W-1:0]             mul_a, mul_b;
   logic [MUL_W-1:0]              mul_p;
   logic [ACC_W-1:0]              sub_b;
   logic [ACC_W:0]                sub_diff;
   logic                          sub_ge;
   logic [LEN_W-1:0]              len;
   logic [QUO_W-1:0]              quo_next;
   logic signed [OFS_W-1:0]       q_ext;

   // vertex
   logic signed [COORD_BITS-1:0]  vx_base, vy_base;
   logic signed [OFS_W-1:0]       vx_ofs, vy_ofs;
   logic [COORD_BITS:0]           vx_sum, vy_sum;
   logic                          out_load;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_x    = out_x_ff;
   assign rsp_vertex_y    = out_y_ff;
   assign rsp_vertex_rgba = out_rgba_ff;
   assign rsp_corner      = out_corner_ff;
   assign rsp_last_of_run = out_last_ff;

   always_comb begin
      priority if (map_zoom_ff < ZOOM_LO) zoom_t = ZOOM_T_MIN;
      else if (map_zoom_ff > ZOOM_HI) zoom_t = ZOOM_T_MAX;
      else zoom_t = T_W'(map_zoom_ff - ZOOM_BIAS);
   end

   assign n_half   = {zoom_t, 10'd7};
   assign q0       = prod_ff[RECIP15_SHIFT+F_W-1:RECIP15_SHIFT];
   assign q0_x15   = {q0, 4'b0000} - {4'b0000, q0};
   assign f_calc   = q0 - F_W'(q0_x15 > (F_W+4)'(n_half)) + F_OFFSET;
   assign we_sum   = prod_ff + WE_ROUND;
   assign we_round = we_sum[WE_W+15:16];

   assign dx_mag     = dx_ff[COORD_BITS] ? -dx_ff : dx_ff;
   assign dy_mag     = dy_ff[COORD_BITS] ? -dy_ff : dy_ff;
   assign norm_shift = CNT_W'(NORM_W - 1) - msb_index(ax_ff[COORD_BITS-1:0] |
                                                      ay_ff[COORD_BITS-1:0]);
   assign zl_sum     = {1'b0, we_ff} + (WE_W+1)'(8);
   assign zl_ofs     = -OFS_W'(zl_sum[WE_W:4]);

   always_comb begin
      unique case (state_ff)
         ST_WID_MUL: begin
            mul_a = NORM_W'(n_half);
            mul_b = NORM_W'(RECIP15);
         end
         ST_WE_MUL: begin
            mul_a = NORM_W'(half_width_ff);
            mul_b = NORM_W'(f_ff);
         end
         ST_SQ_X: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         ST_SQ_Y: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         ST_QUO_MUL: begin
            mul_a = NORM_W'(we_ff);
            mul_b = phase_ff ? ax_ff : ay_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign sub_b    = (state_ff == ST_ROOT) ? root_ff + ACC_W'(bit_ff) : ACC_W'(bit_ff);
   assign sub_diff = {1'b0, rem_ff} - {1'b0, sub_b};
   assign sub_ge   = ~sub_diff[ACC_W];
   assign len      = root_ff[LEN_W-1:0];
   assign quo_next = {quo_ff[QUO_W-2:0], sub_ge};
   assign q_ext    = OFS_W'(quo_next);

   assign vx_base  = corner_ff[0] ? cur_x_ff : prev_x_ff;
   assign vy_base  = corner_ff[0] ? cur_y_ff : prev_y_ff;
   assign vx_ofs   = corner_ff[1] ? -ox_ff : ox_ff;
   assign vy_ofs   = corner_ff[1] ? -oy_ff : oy_ff;
   assign vx_sum   = {vx_base[COORD_BITS-1], vx_base} +
                     {{(COORD_BITS+1-OFS_W){vx_ofs[OFS_W-1]}}, vx_ofs};
   assign vy_sum   = {vy_base[COORD_BITS-1], vy_base} +
                     {{(COORD_BITS+1-OFS_W){vy_ofs[OFS_W-1]}}, vy_ofs};
   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in        = state_ff;
      half_width_in   = half_width_ff;
      map_mode_in     = map_mode_ff;
      map_zoom_in     = map_zoom_ff;
      vertex_color_in = vertex_color_ff;
      prev_x_in       = prev_x_ff;
      prev_y_in       = prev_y_ff;
      have_prev_in    = have_prev_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      last_in         = last_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      ax_in           = ax_ff;
      ay_in           = ay_ff;
      f_in            = f_ff;
      we_in           = we_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      root_in         = root_ff;
      bit_in          = bit_ff;
      cnt_in          = cnt_ff;
      quo_in          = quo_ff;
      phase_in        = phase_ff;
      ox_in           = ox_ff;
      oy_in           = oy_ff;
      corner_in       = corner_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_x_in        = out_x_ff;
      out_y_in        = out_y_ff;
      out_rgba_in     = out_rgba_ff;
      out_corner_in   = out_corner_ff;
      out_last_in     = out_last_ff;

      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_HALF_WIDTH:   half_width_in   = csr_wdata[HW_W-1:0];
            CSR_MAP_MODE:     map_mode_in     = csr_wdata[0];
            CSR_MAP_ZOOM:     map_zoom_in     = csr_wdata[ZOOM_W-1:0];
            CSR_VERTEX_COLOR: vertex_color_in = csr_wdata[RGBA_W-1:0];
            default:          map_mode_in     = map_mode_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_x_in = req_point_x;
               cur_y_in = req_point_y;
               last_in  = req_last_point;
               dx_in    = {req_point_x[COORD_BITS-1], req_point_x} -
                          {prev_x_ff[COORD_BITS-1], prev_x_ff};
               dy_in    = {req_point_y[COORD_BITS-1], req_point_y} -
                          {prev_y_ff[COORD_BITS-1], prev_y_ff};
               if (have_prev_ff) begin
                  we_in    = WE_W'(half_width_ff);
                  state_in = map_mode_ff ? ST_WID_MUL : ST_NORM_ABS;
               end else if (req_last_point) begin
                  prev_x_in    = '0;
                  prev_y_in    = '0;
                  have_prev_in = 1'b0;
               end else begin
                  prev_x_in    = req_point_x;
                  prev_y_in    = req_point_y;
                  have_prev_in = 1'b1;
               end
            end
         end
         ST_WID_MUL: begin
            prod_in  = mul_p;
            state_in = ST_WID_FIX;
         end
         ST_WID_FIX: begin
            f_in     = f_calc;
            state_in = ST_WE_MUL;
         end
         ST_WE_MUL: begin
            prod_in  = mul_p;
            state_in = ST_WE_RND;
         end
         ST_WE_RND: begin
            we_in    = we_round;
            state_in = ST_NORM_ABS;
         end
         ST_NORM_ABS: begin
            ax_in = NORM_W'(dx_mag[COORD_BITS-1:0]);
            ay_in = NORM_W'(dy_mag[COORD_BITS-1:0]);
            if (dx_mag == '0 && dy_mag == '0) begin
               // zero-length segment: normal points straight up
               ox_in     = '0;
               oy_in     = zl_ofs;
               corner_in = CORNER_PREV_MINUS;
               state_in  = ST_EMIT;
            end else begin
               state_in = ST_NORM_SHIFT;
            end
         end
         ST_NORM_SHIFT: begin
            ax_in    = ax_ff << norm_shift;
            ay_in    = ay_ff << norm_shift;
            state_in = ST_SQ_X;
         end
         ST_SQ_X: begin
            prod_in  = mul_p;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            prod_in  = mul_p;
            rem_in   = ACC_W'(prod_ff);
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            rem_in   = rem_ff + ACC_W'(prod_ff);
            root_in  = '0;
            bit_in   = ROOT_BIT_INIT;
            cnt_in   = CNT_W'(ROOT_STEPS - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sub_ge) begin
               rem_in  = sub_diff[ACC_W-1:0];
               root_in = (root_ff >> 1) + ACC_W'(bit_ff);
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               phase_in = 1'b0;
               state_in = ST_QUO_MUL;
            end
         end
         ST_QUO_MUL: begin
            prod_in  = mul_p;
            state_in = ST_QUO_LOAD;
         end
         ST_QUO_LOAD: begin
            // numerator rounded by half the divisor (len*16)
            rem_in   = ACC_W'(prod_ff) + ACC_W'({len, {(DEN_SHIFT-1){1'b0}}});
            bit_in   = (ACC_W-1)'({len, {(DEN_SHIFT+QUO_STEPS-1){1'b0}}});
            quo_in   = '0;
            cnt_in   = CNT_W'(QUO_STEPS - 1);
            state_in = ST_QUO_DIV;
         end
         ST_QUO_DIV: begin
            if (sub_ge) rem_in = sub_diff[ACC_W-1:0];
            quo_in = quo_next;
            bit_in = bit_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (!phase_ff) begin
                  ox_in    = dy_ff[COORD_BITS] ? -q_ext : q_ext;
                  phase_in = 1'b1;
                  state_in = ST_QUO_MUL;
               end else begin
                  oy_in     = dx_ff[COORD_BITS] ? q_ext : -q_ext;
                  corner_in = CORNER_PREV_MINUS;
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               out_x_in      = sat_coord(vx_sum);
               out_y_in      = sat_coord(vy_sum);
               out_rgba_in   = vertex_color_ff;
               out_corner_in = corner_ff;
               out_last_in   = (corner_ff == CORNER_CUR_PLUS);
               corner_in     = corner_ff + 1'b1;
               if (corner_ff == CORNER_CUR_PLUS) begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     prev_x_in    = '0;
                     prev_y_in    = '0;
                     have_prev_in = 1'b0;
                  end else begin
                     prev_x_in    = cur_x_ff;
                     prev_y_in    = cur_y_ff;
                     have_prev_in = 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         half_width_ff   <= HALF_WIDTH_RESET;
         map_mode_ff     <= 1'b0;
         map_zoom_ff     <= MAP_ZOOM_RESET;
         vertex_color_ff <= VERTEX_COLOR_RESET;
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         have_prev_ff    <= 1'b0;
         phase_ff        <= 1'b0;
         cnt_ff          <= '0;
         corner_ff       <= CORNER_PREV_MINUS;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         half_width_ff   <= half_width_in;
         map_mode_ff     <= map_mode_in;
         map_zoom_ff     <= map_zoom_in;
         vertex_color_ff <= vertex_color_in;
         prev_x_ff       <= prev_x_in;
         prev_y_ff       <= prev_y_in;
         have_prev_ff    <= have_prev_in;
         phase_ff        <= phase_in;
         cnt_ff          <= cnt_in;
         corner_ff       <= corner_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      last_ff       <= last_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      f_ff          <= f_in;
      we_ff         <= we_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      quo_ff        <= quo_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_rgba_ff   <= out_rgba_in;
      out_corner_ff <= out_corner_in;
      out_last_ff   <= out_last_in;
   end

endmodule
